[sv/clsk_pkg.sv]
// ----------------------------------------------------------------------------
// clsk_pkg
// Shared codes and types of the call/loop control stack: operation, status
// and entry-kind codes, the entry tag, the result bundle and the level unit's
// outputs.
// ----------------------------------------------------------------------------
package clsk_pkg;

  localparam int LVL_W  = 4;
  localparam int FUNC_W = 4;
  localparam int STAT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_CALL      = 4'd0,
    FN_RETURN    = 4'd1,
    FN_FOR       = 4'd2,
    FN_FORLAST   = 4'd3,
    FN_NEXT      = 4'd4,
    FN_WHILE     = 4'd5,
    FN_WHILEBACK = 4'd6,
    FN_JUMP      = 4'd7,
    FN_INCLUDE   = 4'd8,
    FN_EXIT      = 4'd9,
    FN_RESET     = 4'd10
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_OVER    = 3'd1,
    ST_INVALID = 3'd2,
    ST_NOCALL  = 3'd3,
    ST_NEST    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_CALL  = 2'd1,
    KIND_FOR   = 2'd2,
    KIND_WHILE = 2'd3
  } kind_e;

  // Tag of one stack entry; the saved pointer is stored beside it.
  typedef struct packed {
    logic [LVL_W-1:0] level;
    kind_e            kind;
    logic             ended;
  } meta_t;

  // Result of one item, minus the pointer and the depth.
  typedef struct packed {
    status_e          status;
    logic             redirect;
    logic [LVL_W-1:0] level;
    logic             again;
  } res_t;

  // Outputs of the shared level compare unit.
  typedef struct packed {
    logic             lt;
    logic             eq;
    logic [LVL_W-1:0] inc;
    logic [LVL_W-1:0] dec;
  } cmp_t;

endpackage

[sv/clsk_lvl_unit.sv]
// ----------------------------------------------------------------------------
// clsk_lvl_unit
// Shared nesting-level unit: compares two levels and forms the first one
// plus and minus one.
// ----------------------------------------------------------------------------
module clsk_lvl_unit import clsk_pkg::*; (
  input  logic [LVL_W-1:0] a_i,
  input  logic [LVL_W-1:0] b_i,
  output cmp_t             res_o
);

  assign res_o.lt  = (a_i < b_i);
  assign res_o.eq  = (a_i == b_i);
  assign res_o.inc = a_i + 1'b1;
  assign res_o.dec = a_i - 1'b1;

endmodule

[sv/clsk_stack_mem.sv]
// ----------------------------------------------------------------------------
// clsk_stack_mem
// Stack entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clsk_stack_mem import clsk_pkg::*; #(
  parameter int DEPTH = 10,
  parameter int PTR_W = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PTR_W-1:0] wptr_i,
  input  meta_t            wmeta_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [PTR_W-1:0] rd_ptr_o,
  output meta_t            rd_meta_o
);

  localparam int MW = $bits(meta_t);
  localparam int EW = PTR_W + MW;

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wptr_i, wmeta_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rd_ptr_o  = rdata_q[EW-1 -: PTR_W];
  assign rd_meta_o = meta_t'(rdata_q[MW-1:0]);

endmodule

[sv/clsk_ctrl.sv]
// ----------------------------------------------------------------------------
// clsk_ctrl
// Sequencer of the control stack: decodes one item, checks the top entry,
// pushes or pops, and walks down the stack to drop entries above a level.
// ----------------------------------------------------------------------------
module clsk_ctrl import clsk_pkg::*; #(
  parameter int STACK_DEPTH = 10,
  parameter int NEST_LEVELS = 10,
  parameter int PTR_WIDTH   = 16,
  parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [PTR_WIDTH-1:0] target_ptr_i,
  input  logic [LVL_W-1:0]     target_level_i,
  input  logic [PTR_WIDTH-1:0] line_start_i,
  input  logic [PTR_WIDTH-1:0] resume_ptr_i,
  input  logic                 out_free_i,
  output logic                 idle_o,
  output logic                 done_o,
  output res_t                 res_o,
  output logic [PTR_WIDTH-1:0] rptr_o,
  output logic [DW-1:0]        depth_o
);

  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_TOP, S_DREAD, S_DCHK, S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [PTR_WIDTH-1:0] tptr_q, tptr_d;
  logic [LVL_W-1:0]     tlev_q, tlev_d;
  logic [PTR_WIDTH-1:0] lstart_q, lstart_d;
  logic [PTR_WIDTH-1:0] resume_q, resume_d;
  logic [DW-1:0]        depth_q, depth_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [LVL_W-1:0]     thr_q, thr_d;
  status_e              status_q, status_d;
  logic                 redir_q, redir_d;
  logic [PTR_WIDTH-1:0] rptr_q, rptr_d;
  logic                 again_q, again_d;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [PTR_WIDTH-1:0] mem_wptr, rd_ptr;
  meta_t                mem_wmeta, rd_meta;

  logic [LVL_W-1:0]     alu_a, alu_b;
  cmp_t                 cmp;

  logic [DW-1:0]        depth_m1;
  logic [AW-1:0]        top_addr, push_addr;
  logic                 full, empty;

  clsk_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .PTR_W (PTR_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wptr_i    (mem_wptr),
    .wmeta_i   (mem_wmeta),
    .re_i      (mem_re),
    .raddr_i   (mem_raddr),
    .rd_ptr_o  (rd_ptr),
    .rd_meta_o (rd_meta)
  );

  clsk_lvl_unit u_lvl (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (cmp)
  );

  assign depth_m1  = depth_q - 1'b1;
  assign top_addr  = depth_m1[AW-1:0];
  assign push_addr = depth_q[AW-1:0];
  assign full      = (depth_q == DW'(STACK_DEPTH));
  assign empty     = (depth_q == '0);

  always_comb begin
    kind_e want;
    want      = KIND_CALL;
    state_d   = state_q;
    func_d    = func_q;
    tptr_d    = tptr_q;
    tlev_d    = tlev_q;
    lstart_d  = lstart_q;
    resume_d  = resume_q;
    depth_d   = depth_q;
    level_d   = level_q;
    thr_d     = thr_q;
    status_d  = status_q;
    redir_d   = redir_q;
    rptr_d    = rptr_q;
    again_d   = again_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = push_addr;
    mem_raddr = top_addr;
    mem_wptr  = lstart_q;
    mem_wmeta = '{level: level_q, kind: KIND_FOR, ended: 1'b0};
    alu_a     = level_q;
    alu_b     = level_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          tptr_d   = target_ptr_i;
          tlev_d   = target_level_i;
          lstart_d = line_start_i;
          resume_d = resume_ptr_i;
          status_d = ST_OK;
          redir_d  = 1'b0;
          rptr_d   = '0;
          again_d  = 1'b0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_FIN;
        case (func_e'(func_q))
          FN_CALL: begin
            alu_a = tlev_q;
            alu_b = level_q;
            if (!cmp.eq) begin
              status_d = ST_NOCALL;
            end else if (full) begin
              status_d = ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wptr  = resume_q;
              mem_wmeta = '{level: level_q, kind: KIND_CALL, ended: 1'b0};
              depth_d   = depth_q + 1'b1;
              redir_d   = 1'b1;
              rptr_d    = tptr_q;
            end
          end
          FN_FOR, FN_WHILE: begin
            if (full) begin
              status_d = ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wptr  = lstart_q;
              mem_wmeta = '{level: level_q,
                            kind: (func_e'(func_q) == FN_FOR) ? KIND_FOR : KIND_WHILE,
                            ended: 1'b0};
              depth_d   = depth_q + 1'b1;
            end
          end
          FN_RETURN, FN_WHILEBACK, FN_NEXT: begin
            if (empty) begin
              status_d = ST_INVALID;
            end else begin
              mem_re  = 1'b1;
              state_d = S_TOP;
            end
          end
          FN_FORLAST: begin
            if (!empty) begin
              mem_re  = 1'b1;
              state_d = S_TOP;
            end
          end
          FN_JUMP: begin
            alu_a   = tlev_q;
            alu_b   = level_q;
            redir_d = 1'b1;
            rptr_d  = tptr_q;
            if (cmp.lt) begin
              level_d = tlev_q;
              thr_d   = cmp.inc;
              state_d = S_DREAD;
            end
          end
          FN_INCLUDE: begin
            alu_a = level_q;
            alu_b = LVL_W'(NEST_LEVELS - 1);
            if (!cmp.lt) begin
              status_d = ST_NEST;
            end else begin
              level_d = cmp.inc;
              redir_d = 1'b1;
              rptr_d  = '0;
            end
          end
          FN_EXIT: begin
            alu_a = level_q;
            alu_b = '0;
            if (cmp.eq) begin
              status_d = ST_NEST;
            end else begin
              thr_d   = level_q;
              level_d = cmp.dec;
              state_d = S_DREAD;
            end
          end
          FN_RESET: begin
            depth_d = '0;
            level_d = '0;
          end
          default: begin
            status_d = ST_INVALID;
          end
        endcase
      end

      S_TOP: begin
        alu_a   = rd_meta.level;
        alu_b   = level_q;
        state_d = S_FIN;
        case (func_e'(func_q))
          FN_RETURN, FN_WHILEBACK: begin
            want = (func_e'(func_q) == FN_RETURN) ? KIND_CALL : KIND_WHILE;
            if (rd_meta.kind != want) begin
              status_d = ST_INVALID;
            end else begin
              depth_d = depth_m1;
              redir_d = 1'b1;
              rptr_d  = rd_ptr;
              if (cmp.lt) begin
                level_d = rd_meta.level;
                thr_d   = cmp.inc;
                state_d = S_DREAD;
              end
            end
          end
          FN_FORLAST: begin
            if (rd_meta.kind == KIND_FOR) begin
              mem_we    = 1'b1;
              mem_waddr = top_addr;
              mem_wptr  = rd_ptr;
              mem_wmeta = '{level: rd_meta.level, kind: KIND_FOR, ended: 1'b1};
            end
          end
          FN_NEXT: begin
            if (rd_meta.kind != KIND_FOR) begin
              status_d = ST_INVALID;
            end else if (rd_meta.ended) begin
              depth_d = depth_m1;
            end else begin
              redir_d = 1'b1;
              rptr_d  = rd_ptr;
              again_d = 1'b1;
              if (cmp.lt) begin
                level_d = rd_meta.level;
                thr_d   = cmp.inc;
                state_d = S_DREAD;
              end
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      // Walk down from the top, one entry per read/check pair.
      S_DREAD: begin
        if (empty) begin
          state_d = S_FIN;
        end else begin
          mem_re  = 1'b1;
          state_d = S_DCHK;
        end
      end

      S_DCHK: begin
        alu_a = rd_meta.level;
        alu_b = thr_q;
        if (!cmp.lt) begin
          depth_d = depth_m1;
          state_d = S_DREAD;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      func_q   <= '0;
      tptr_q   <= '0;
      tlev_q   <= '0;
      lstart_q <= '0;
      resume_q <= '0;
      depth_q  <= '0;
      level_q  <= '0;
      thr_q    <= '0;
      status_q <= ST_OK;
      redir_q  <= 1'b0;
      rptr_q   <= '0;
      again_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      func_q   <= func_d;
      tptr_q   <= tptr_d;
      tlev_q   <= tlev_d;
      lstart_q <= lstart_d;
      resume_q <= resume_d;
      depth_q  <= depth_d;
      level_q  <= level_d;
      thr_q    <= thr_d;
      status_q <= status_d;
      redir_q  <= redir_d;
      rptr_q   <= rptr_d;
      again_q  <= again_d;
    end
  end

  assign idle_o       = (state_q == S_IDLE);
  assign done_o       = (state_q == S_FIN) && out_free_i;
  assign res_o.status = status_q;
  assign res_o.redirect = redir_q;
  assign res_o.level  = level_q;
  assign res_o.again  = again_q;
  assign rptr_o       = rptr_q;
  assign depth_o      = depth_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(NEST_LEVELS - 1))
    else $error("nesting level beyond limit");

  a_fail_no_redirect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q != ST_OK)) |-> !redir_q)
    else $error("failing item carries a redirect");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> ($stable(depth_q) && $stable(level_q)))
    else $error("stack state moved while idle");

  a_walk_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DCHK) |=> (depth_q <= $past(depth_q)))
    else $error("discard walk grew the stack");
`endif

endmodule

[sv/call_loop_control_stack.sv]
// ----------------------------------------------------------------------------
// call_loop_control_stack
// Control stack of a script sequencer: call/return, for/next and while loops,
// jumps, include and exit of nesting levels, with one result per item.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. The block handles one
// item at a time: in_stall_o is high from acceptance until the result has
// been placed in the output register, which then holds it for the consumer
// while the next item is already taken in. An item that neither reads the
// stack top nor walks the stack (call, for, while, jump without level drop,
// include, refused exit, reset) passes through the decode and finish steps:
// the result is loaded into the output register as the finish step ends,
// and the sequencer returns to idle to take the next item. Reading the top
// entry (return, next, whileback, forlast on a non-empty stack) adds a top
// check step. Dropping entries above a lowered level (exit, jump or pop that
// lowers the level) adds a read step and a check step for every stack entry
// examined, plus a final read step when the walk runs the stack empty. The
// walk is paced by the single-read-port stack memory, whose read data is
// registered. A result that cannot enter the output register because the
// previous one is still stalled there holds the sequencer in its finish step.
module call_loop_control_stack import clsk_pkg::*; #(
  parameter int STACK_DEPTH = 10,
  parameter int NEST_LEVELS = 10,
  parameter int PTR_WIDTH   = 16,
  localparam int DW         = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [PTR_WIDTH-1:0] target_ptr_i,
  input  logic [LVL_W-1:0]     target_level_i,
  input  logic [PTR_WIDTH-1:0] line_start_i,
  input  logic [PTR_WIDTH-1:0] resume_ptr_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STAT_W-1:0]    status_o,
  output logic                 redirect_o,
  output logic [PTR_WIDTH-1:0] redirect_ptr_o,
  output logic [LVL_W-1:0]     level_now_o,
  output logic                 loop_again_o,
  output logic [DW-1:0]        stack_depth_o
);

  logic                 ctrl_idle;
  logic                 ctrl_done;
  logic                 start;
  logic                 out_free;
  res_t                 ctrl_res;
  logic [PTR_WIDTH-1:0] ctrl_rptr;
  logic [DW-1:0]        ctrl_depth;

  logic                 out_valid_q, out_valid_d;
  res_t                 res_q;
  logic [PTR_WIDTH-1:0] rptr_q;
  logic [DW-1:0]        depth_q;

  // Take an item only while the sequencer sits idle.
  assign in_stall_o = !ctrl_idle;
  assign start      = in_valid_i && ctrl_idle;

  // The output register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  clsk_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .NEST_LEVELS (NEST_LEVELS),
    .PTR_WIDTH   (PTR_WIDTH),
    .DW          (DW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .func_i         (func_i),
    .target_ptr_i   (target_ptr_i),
    .target_level_i (target_level_i),
    .line_start_i   (line_start_i),
    .resume_ptr_i   (resume_ptr_i),
    .out_free_i     (out_free),
    .idle_o         (ctrl_idle),
    .done_o         (ctrl_done),
    .res_o          (ctrl_res),
    .rptr_o         (ctrl_rptr),
    .depth_o        (ctrl_depth)
  );

  // Hold the result until taken; drop the valid once it leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; loaded only on completion, so a stalled result holds.
  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      res_q   <= ctrl_res;
      rptr_q  <= ctrl_rptr;
      depth_q <= ctrl_depth;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign redirect_o     = res_q.redirect;
  assign redirect_ptr_o = rptr_q;
  assign level_now_o    = res_q.level;
  assign loop_again_o   = res_q.again;
  assign stack_depth_o  = depth_q;

endmodule

[bench/call_loop_control_stack_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_loop_control_stack_test
// Self-checking bench for the script control stack. A short table of
// directed items covers the empty stack, the unknown codes, bad label levels
// and each loop form. Random script-like traffic follows and is scored
// against a behavioral copy of the stack, with random stalls on both sides.
// ----------------------------------------------------------------------------
module call_loop_control_stack_test;
  import clsk_pkg::*;

  localparam int STACK_DEPTH = 10;
  localparam int NEST_LEVELS = 10;
  localparam int PTR_WIDTH   = 16;
  localparam int RAND_ITEMS  = 1200;

  // Codes the block does not define; it must refuse them.
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 4'd11;
  localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = 4'd15;

  typedef struct packed {
    logic [FUNC_W-1:0]    fn;
    logic [PTR_WIDTH-1:0] tptr;
    logic [LVL_W-1:0]     tlev;
    logic [PTR_WIDTH-1:0] lstart;
    logic [PTR_WIDTH-1:0] resume;
  } ctl_item_t;

  typedef struct packed {
    status_e              status;
    logic                 redirect;
    logic [PTR_WIDTH-1:0] rptr;
    logic [LVL_W-1:0]     level;
    logic                 again;
    logic [3:0]           depth;
  } ctl_result_t;

  // One row of the directed table; a typed row carries its own answer.
  typedef struct {
    ctl_item_t   item;
    bit          typed;
    ctl_result_t result;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Ports of the block; its inputs are all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [FUNC_W-1:0]    func_i         = '0;
  logic [PTR_WIDTH-1:0] target_ptr_i   = '0;
  logic [LVL_W-1:0]     target_level_i = '0;
  logic [PTR_WIDTH-1:0] line_start_i   = '0;
  logic [PTR_WIDTH-1:0] resume_ptr_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic                 redirect_o;
  logic [PTR_WIDTH-1:0] redirect_ptr_o;
  logic [LVL_W-1:0]     level_now_o;
  logic                 loop_again_o;
  logic [3:0]           stack_depth_o;

  call_loop_control_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .NEST_LEVELS(NEST_LEVELS),
    .PTR_WIDTH  (PTR_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .target_ptr_i  (target_ptr_i),
    .target_level_i(target_level_i),
    .line_start_i  (line_start_i),
    .resume_ptr_i  (resume_ptr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .redirect_o    (redirect_o),
    .redirect_ptr_o(redirect_ptr_o),
    .level_now_o   (level_now_o),
    .loop_again_o  (loop_again_o),
    .stack_depth_o (stack_depth_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: several times the slowest legal run (about 1225 items, each
  // held at most by a full discard walk plus random gaps and stalls on both sides).
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow control stack; it advances when an item is accepted
  // --------------------------------------------------------------------------
  logic [PTR_WIDTH-1:0] stk_ptr   [STACK_DEPTH];
  logic [LVL_W-1:0]     stk_level [STACK_DEPTH];
  kind_e                stk_kind  [STACK_DEPTH];
  logic                 stk_ended [STACK_DEPTH];
  int                   stk_depth = 0;
  int                   nest_lvl  = 0;

  ctl_result_t pending_results[$];
  int          mismatches = 0;

  // Answer typed into the directed table for the item now on the bus.
  bit          typed_pending = 1'b0;
  ctl_result_t typed_result  = '0;

  // Traffic shaping knobs of the random part.
  bit steady_flow = 1'b0;
  int push_mode   = 1;
  int nest_mode   = 1;

  // Drop top entries made at level lvl or deeper.
  function automatic void discard_from(int lvl);
    while (stk_depth > 0 && stk_level[stk_depth-1] >= lvl) stk_depth--;
  endfunction

  function automatic void lower_to(int lvl);
    if (lvl < nest_lvl) begin
      nest_lvl = lvl;
      discard_from(lvl + 1);
    end
  endfunction

  function automatic bit push_entry(logic [PTR_WIDTH-1:0] p, kind_e k);
    if (stk_depth >= STACK_DEPTH) return 1'b0;
    stk_ptr[stk_depth]   = p;
    stk_level[stk_depth] = LVL_W'(nest_lvl);
    stk_kind[stk_depth]  = k;
    stk_ended[stk_depth] = 1'b0;
    stk_depth++;
    return 1'b1;
  endfunction

  function automatic bit top_is(kind_e k);
    return stk_depth > 0 && stk_kind[stk_depth-1] == k;
  endfunction

  // Apply one control operation to the shadow stack and return its result.
  function automatic ctl_result_t apply_control_op(ctl_item_t it);
    ctl_result_t r;
    kind_e       need;
    int          top;
    r   = '0;
    top = stk_depth - 1;
    case (it.fn)
      FN_CALL: begin
        if (it.tlev != nest_lvl) begin
          r.status = ST_NOCALL;
        end else if (!push_entry(it.resume, KIND_CALL)) begin
          r.status = ST_OVER;
        end else begin
          r.redirect = 1'b1;
          r.rptr     = it.tptr;
        end
      end
      FN_RETURN, FN_WHILEBACK: begin
        if (it.fn == FN_RETURN) need = KIND_CALL;
        else need = KIND_WHILE;
        if (!top_is(need)) begin
          r.status = ST_INVALID;
        end else begin
          stk_depth--;
          r.rptr     = stk_ptr[stk_depth];
          r.redirect = 1'b1;
          lower_to(stk_level[stk_depth]);
        end
      end
      FN_FOR: begin
        if (!push_entry(it.lstart, KIND_FOR)) r.status = ST_OVER;
      end
      FN_WHILE: begin
        if (!push_entry(it.lstart, KIND_WHILE)) r.status = ST_OVER;
      end
      FN_FORLAST: begin
        if (top_is(KIND_FOR)) stk_ended[top] = 1'b1;
      end
      FN_NEXT: begin
        if (!top_is(KIND_FOR)) begin
          r.status = ST_INVALID;
        end else if (stk_ended[top]) begin
          stk_depth--;
        end else begin
          r.rptr     = stk_ptr[top];
          r.redirect = 1'b1;
          r.again    = 1'b1;
          lower_to(stk_level[top]);
        end
      end
      FN_JUMP: begin
        lower_to(it.tlev);
        r.redirect = 1'b1;
        r.rptr     = it.tptr;
      end
      FN_INCLUDE: begin
        if (nest_lvl >= NEST_LEVELS - 1) begin
          r.status = ST_NEST;
        end else begin
          nest_lvl++;
          r.redirect = 1'b1;
        end
      end
      FN_EXIT: begin
        if (nest_lvl < 1) begin
          r.status = ST_NEST;
        end else begin
          discard_from(nest_lvl);
          nest_lvl--;
        end
      end
      FN_RESET: begin
        stk_depth = 0;
        nest_lvl  = 0;
      end
      default: r.status = ST_INVALID;
    endcase
    r.level = LVL_W'(nest_lvl);
    r.depth = 4'(stk_depth);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: retire results first, then log the item taken this edge
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [PTR_WIDTH-1:0] want,
                             logic [PTR_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    ctl_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got status %0h ptr %0h",
                 $time, status_o, redirect_ptr_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("redirect", want.redirect, redirect_o);
        check_field("redirect_ptr", want.rptr, redirect_ptr_o);
        check_field("level_now", want.level, level_now_o);
        check_field("loop_again", want.again, loop_again_o);
        check_field("stack_depth", want.depth, stack_depth_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      // Advance the shadow stack even when the row supplies its own answer.
      want = apply_control_op('{func_i, target_ptr_i, target_level_i,
                                 line_start_i, resume_ptr_i});
      if (typed_pending) want = typed_result;
      pending_results.push_back(want);
    end
  end

  // Receiver: stall about 14 percent of the time, never in the steady stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(0, 99) < 14);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic ctl_item_t itm(logic [FUNC_W-1:0] fn, logic [PTR_WIDTH-1:0] tptr,
                                    logic [LVL_W-1:0] tlev, logic [PTR_WIDTH-1:0] lstart,
                                    logic [PTR_WIDTH-1:0] resume);
    return '{fn, tptr, tlev, lstart, resume};
  endfunction

  function automatic ctl_result_t rslt(status_e s, logic rd, logic [PTR_WIDTH-1:0] p,
                                       logic [LVL_W-1:0] l, logic a, logic [3:0] d);
    return '{s, rd, p, l, a, d};
  endfunction

  // Script-like random op, shaped by the shadow stack so that most pops
  // match the top entry and calls hit the current level.
  function automatic ctl_item_t pick_script_op();
    ctl_item_t it;
    int        roll;
    int        push_pct;
    int        incl_pct;
    it.fn     = FN_RESET;
    it.tptr   = PTR_WIDTH'($urandom);
    it.tlev   = LVL_W'($urandom_range(0, 15));
    it.lstart = PTR_WIDTH'($urandom);
    it.resume = PTR_WIDTH'($urandom);
    push_pct  = (push_mode == 0) ? 60 : (push_mode == 1) ? 35 : 15;
    incl_pct  = (nest_mode == 0) ? 80 : (nest_mode == 1) ? 50 : 20;
    roll      = $urandom_range(0, 99);
    if (roll < 5) begin
      // Noise: any code, unknown ones included.
      it.fn = FUNC_W'($urandom_range(0, 15));
      return it;
    end
    if (roll == 5) return it;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      case ($urandom_range(0, 2))
        0: begin
          it.fn = FN_CALL;
          if ($urandom_range(0, 9) != 0) it.tlev = LVL_W'(nest_lvl);
        end
        1: it.fn = FN_FOR;
        default: it.fn = FN_WHILE;
      endcase
    end else if (roll < push_pct + 30) begin
      if (stk_depth == 0 || $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: it.fn = FN_RETURN;
          1: it.fn = FN_NEXT;
          2: it.fn = FN_FORLAST;
          default: it.fn = FN_WHILEBACK;
        endcase
      end else begin
        case (stk_kind[stk_depth-1])
          KIND_CALL: it.fn = FN_RETURN;
          KIND_FOR: it.fn = ($urandom_range(0, 2) == 0) ? FN_FORLAST : FN_NEXT;
          default: it.fn = FN_WHILEBACK;
        endcase
      end
    end else if ($urandom_range(0, 3) == 0) begin
      it.fn = FN_JUMP;
      if ($urandom_range(0, 4) != 0) it.tlev = LVL_W'($urandom_range(0, nest_lvl));
    end else begin
      it.fn = ($urandom_range(0, 99) < incl_pct) ? FN_INCLUDE : FN_EXIT;
    end
    return it;
  endfunction

  // Drive one item from a falling edge and hold it until it is taken.
  // Returns on the falling edge after acceptance with valid still high.
  task automatic send_item(ctl_item_t it, bit typed, ctl_result_t answer);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    typed_pending = typed;
    typed_result  = answer;
    in_valid_i     <= 1'b1;
    func_i         <= it.fn;
    target_ptr_i   <= it.tptr;
    target_level_i <= it.tlev;
    line_start_i   <= it.lstart;
    resume_ptr_i   <= it.resume;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  initial begin
    // Empty stack at level 0: refuse every pop, exit and unknown code.
    dir_rows.push_back('{itm(FN_NEXT, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_RETURN, 16'hFFFF, 4'd0, 16'hFFFF, 16'hFFFF), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_WHILEBACK, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_EXIT, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_NEST, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_LAST_UNUSED, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_FIRST_UNUSED, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    // Label level out of range: the call cannot be made.
    dir_rows.push_back('{itm(FN_CALL, 16'h1111, 4'd15, 16'h0000, 16'h2222), 1'b1,
                         rslt(ST_NOCALL, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    // Call and return round trip; a forlast on a call entry does nothing.
    dir_rows.push_back('{itm(FN_CALL, 16'hFFFF, 4'd0, 16'h0000, 16'h1234), 1'b1,
                         rslt(ST_OK, 1'b1, 16'hFFFF, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_FORLAST, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_RETURN, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b1, 16'h1234, 4'd0, 1'b0, 4'd0)});
    // For loop: repeat once, mark the last pass, then leave it.
    dir_rows.push_back('{itm(FN_FOR, 16'h0000, 4'd0, 16'hFFFF, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_NEXT, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b1, 16'hFFFF, 4'd0, 1'b1, 4'd1)});
    dir_rows.push_back('{itm(FN_FORLAST, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_NEXT, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});
    // While loop; a next on a while entry is a kind mismatch.
    dir_rows.push_back('{itm(FN_WHILE, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_NEXT, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_INVALID, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd1)});
    dir_rows.push_back('{itm(FN_WHILEBACK, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b1, 16'h0000, 4'd0, 1'b0, 4'd0)});
    dir_rows.push_back('{itm(FN_INCLUDE, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b1,
                         rslt(ST_OK, 1'b1, 16'h0000, 4'd1, 1'b0, 4'd0)});
    // Nest deeper, stack entries there, then a jump back to level 0
    // drops them all; a jump to a deeper label keeps the level.
    dir_rows.push_back('{itm(FN_INCLUDE, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{itm(FN_FOR, 16'h0000, 4'd0, 16'hA5A5, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{itm(FN_CALL, 16'h5A5A, 4'd2, 16'h0000, 16'hC3C3), 1'b0, '0});
    dir_rows.push_back('{itm(FN_JUMP, 16'h0F0F, 4'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{itm(FN_INCLUDE, 16'h0000, 4'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{itm(FN_JUMP, 16'hF0F0, 4'd9, 16'h0000, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{itm(FN_RESET, 16'hFFFF, 4'd9, 16'hFFFF, 16'hFFFF), 1'b1,
                         rslt(ST_OK, 1'b0, 16'h0000, 4'd0, 1'b0, 4'd0)});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

    // Let the directed part settle fully before random traffic starts.
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Re-roll the push/pop and include/exit balance every 64 items so the
      // stack swings between empty, full and the deepest level.
      if (n % 64 == 0) begin
        push_mode = $urandom_range(0, 2);
        nest_mode = $urandom_range(0, 2);
      end
      steady_flow = (n >= 400 && n < 600);
      if (n == 800) drain_results();
      send_item(pick_script_op(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    steady_flow = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // Watch a while longer for stray results.
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
